// File: hdl/gaussian_sobel_edge_detect_top_assert.svh
// ----------------------------------------------------------------------------
// gaussian sobel edge detect assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_SOBEL_EDGE_DETECT_TOP_ASSERT_SVH
`define GAUSSIAN_SOBEL_EDGE_DETECT_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define GSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/gse_pkg.sv
// ----------------------------------------------------------------------------
// gse_pkg
// shared constants, types and config codes of the gaussian/sobel edge detector
// ----------------------------------------------------------------------------
package gse_pkg;

  // sizing
  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);

  // config register widths
  localparam int WID_W      = 11;
  localparam int HGT_W      = 12;
  localparam int THR_W      = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = HGT_W;

  // config reset values
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  localparam int THR_RST    = 0;

  // geometry
  localparam int MIN_SIZE    = 5;
  localparam int BLUR_START  = 2;
  localparam int RES_START   = 4;

  // datapath widths
  localparam int BLUR_W    = PIXEL_BITS + 4;
  localparam int COLSUM_W  = BLUR_W + 2;
  localparam int GRAD_W    = COLSUM_W + 1;
  localparam int SQ_W      = 2 * GRAD_W - 1;
  localparam int MAG_W     = 29;
  localparam int SUM_W     = (SQ_W + 1 > MAG_W) ? SQ_W + 1 : MAG_W;
  localparam int THR_SQ_W  = 2 * THR_W;
  localparam int CMP_W     = (SUM_W > THR_SQ_W) ? SUM_W : THR_SQ_W;

  // gaussian kernel 1 2 1 / 2 4 2 / 1 2 1 as shift amounts
  localparam int GAUSS_SHIFT [3][3] = '{'{0, 1, 0}, '{1, 2, 1}, '{0, 1, 0}};

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_t;

  // position info of one accepted item
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             cur;
    logic             blur_en;
    logic             res_en;
    logic             last;
  } pos_t;

  // blurred window handed to the gradient stage
  typedef logic [2:0][2:0][BLUR_W-1:0] blur_win_t;

  typedef struct packed {
    logic valid;
    logic last;
  } win_ctl_t;

endpackage

// File: hdl/gaussian_sobel_edge_detect_top.sv
// ----------------------------------------------------------------------------
// gaussian_sobel_edge_detect_top: 3x3 gaussian blur then sobel edge detect
// a pixel goes through stage one, window, gradient, square and result registers
// throughput: one pixel per cycle while out_stall is low, set by the line store read/write port pair
// reset clears counters, windows, config and pipeline valids; line stores and pipeline data not cleared
// ----------------------------------------------------------------------------
module gaussian_sobel_edge_detect_top import gse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MAG_W-1:0]      out_magnitude_sq,
  output logic                  out_edge_res,
  output logic                  out_last_of_frame,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WID_W-1:0]    width_r;
  logic [HGT_W-1:0]    height_r;
  logic [THR_W-1:0]    thr_r;
  logic [THR_SQ_W-1:0] thr_sq_r;
  logic                in_ready, in_acc, win_take;
  pos_t                pos;
  win_ctl_t            win_ctl;
  blur_win_t           blur_win;

  assign cfg_ready = 1'b1;
  assign in_stall  = !in_ready;
  assign in_acc    = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(WIDTH_RST);
      height_r <= HGT_W'(HEIGHT_RST);
      thr_r    <= THR_W'(THR_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:    width_r  <= cfg_data[WID_W-1:0];
        CFG_IMAGE_HEIGHT:   height_r <= cfg_data[HGT_W-1:0];
        CFG_EDGE_THRESHOLD: thr_r    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // squared threshold, refreshed every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_sq_r <= '0;
    end else begin
      thr_sq_r <= THR_SQ_W'(thr_r) * THR_SQ_W'(thr_r);
    end
  end

  gse_pos u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_acc     (in_acc),
    .image_width  (width_r),
    .image_height (height_r),
    .pos          (pos)
  );

  gse_blur u_blur (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .pos      (pos),
    .pixel    (in_pixel),
    .win_take (win_take),
    .in_ready (in_ready),
    .win_ctl  (win_ctl),
    .blur_win (blur_win)
  );

  gse_grad u_grad (
    .clk               (clk),
    .rst_n             (rst_n),
    .win_ctl           (win_ctl),
    .blur_win          (blur_win),
    .thr_sq            (thr_sq_r),
    .out_stall         (out_stall),
    .win_take          (win_take),
    .out_valid         (out_valid),
    .out_magnitude_sq  (out_magnitude_sq),
    .out_edge_res      (out_edge_res),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

// File: hdl/gse_pos.sv
// ----------------------------------------------------------------------------
// gse_pos
// raster position counters; gives column, line slot and border flags per item
// ----------------------------------------------------------------------------
module gse_pos import gse_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_acc,
  input  logic [WID_W-1:0] image_width,
  input  logic [HGT_W-1:0] image_height,
  output pos_t             pos
);

  localparam int RW1 = ROW_W + 1;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] r;
  logic [RW1-1:0]   row_a;
  logic [RW1-1:0]   row_b;
  logic [WID_W-1:0] col_inc;

  // clamp the frame size
  always_comb begin
    if (image_width < WID_W'(MIN_SIZE)) begin
      w_eff = WID_W'(MIN_SIZE);
    end else if (image_width > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height < HGT_W'(MIN_SIZE)) ? HGT_W'(MIN_SIZE) : image_height;
  end

  // position of this item, ending the row or frame early if sizes shrank
  always_comb begin
    if (WID_W'(col_r) >= w_eff) begin
      c     = '0;
      row_a = RW1'(row_r) + RW1'(1);
    end else begin
      c     = col_r;
      row_a = RW1'(row_r);
    end
    r = (row_a >= RW1'(h_eff)) ? '0 : row_a[ROW_W-1:0];
  end

  // position of the next item
  always_comb begin
    col_inc = WID_W'(c) + WID_W'(1);
    row_b   = RW1'(r) + RW1'(1);
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_b >= RW1'(h_eff)) ? '0 : row_b[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = r;
    end
  end

  // item flags
  always_comb begin
    pos.col     = c;
    pos.cur     = r[0];
    pos.blur_en = (r >= ROW_W'(BLUR_START)) && (c >= COL_W'(BLUR_START));
    pos.res_en  = (r >= ROW_W'(RES_START)) && (c >= COL_W'(RES_START));
    pos.last    = (r == h_eff - HGT_W'(1)) && (WID_W'(c) == w_eff - WID_W'(1));
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (item_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: hdl/gse_blur.sv
// ----------------------------------------------------------------------------
// gse_blur
// line stores, pixel window, gaussian blur and blurred window
// ----------------------------------------------------------------------------
module gse_blur import gse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_acc,
  input  pos_t                  pos,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic                  win_take,
  output logic                  in_ready,
  output win_ctl_t              win_ctl,
  output blur_win_t             blur_win
);

  typedef logic [2:0][2:0][PIXEL_BITS-1:0] pix_win_t;

  // line stores: one word per column holds both line slots
  logic [2*PIXEL_BITS-1:0] pix_mem  [MAX_WIDTH];
  logic [2*BLUR_W-1:0]     blur_mem [MAX_WIDTH];

  logic [2*PIXEL_BITS-1:0] pix_rd_r;
  logic [2*BLUR_W-1:0]     blur_rd_r;

  logic                    s1_valid_r;
  pos_t                    s1_pos_r;
  logic [PIXEL_BITS-1:0]   s1_pix_r;

  pix_win_t                pwin_r, pwin_nxt;
  blur_win_t               bwin_r, bwin_nxt;
  win_ctl_t                win_ctl_r;

  logic [PIXEL_BITS-1:0]   top_p, mid_p;
  logic [BLUR_W-1:0]       top_b, mid_b;
  logic [BLUR_W-1:0]       blur_sum, blur_val;
  logic [2*PIXEL_BITS-1:0] pix_wr;
  logic [2*BLUR_W-1:0]     blur_wr;
  logic                    ready2, adv1;

  // handshake between stages
  assign ready2   = !win_ctl_r.valid || win_take;
  assign adv1     = s1_valid_r && ready2;
  assign in_ready = !s1_valid_r || ready2;

  // line slot select: cur slot holds two rows up, the other one row up
  always_comb begin
    if (s1_pos_r.cur) begin
      top_p = pix_rd_r[2*PIXEL_BITS-1:PIXEL_BITS];
      mid_p = pix_rd_r[PIXEL_BITS-1:0];
      top_b = blur_rd_r[2*BLUR_W-1:BLUR_W];
      mid_b = blur_rd_r[BLUR_W-1:0];
    end else begin
      top_p = pix_rd_r[PIXEL_BITS-1:0];
      mid_p = pix_rd_r[2*PIXEL_BITS-1:PIXEL_BITS];
      top_b = blur_rd_r[BLUR_W-1:0];
      mid_b = blur_rd_r[2*BLUR_W-1:BLUR_W];
    end
  end

  // pixel window shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pwin_nxt[i][0] = pwin_r[i][1];
      pwin_nxt[i][1] = pwin_r[i][2];
    end
    pwin_nxt[0][2] = top_p;
    pwin_nxt[1][2] = mid_p;
    pwin_nxt[2][2] = s1_pix_r;
  end

  // gaussian blur over the shifted window
  always_comb begin
    blur_sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        blur_sum = blur_sum + (BLUR_W'(pwin_nxt[i][j]) << GAUSS_SHIFT[i][j]);
      end
    end
    blur_val = s1_pos_r.blur_en ? blur_sum : '0;
  end

  // blurred window shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bwin_nxt[i][0] = bwin_r[i][1];
      bwin_nxt[i][1] = bwin_r[i][2];
    end
    bwin_nxt[0][2] = top_b;
    bwin_nxt[1][2] = mid_b;
    bwin_nxt[2][2] = blur_val;
  end

  // write-back words, new value into the cur slot
  always_comb begin
    if (s1_pos_r.cur) begin
      pix_wr  = {s1_pix_r, mid_p};
      blur_wr = {blur_val, mid_b};
    end else begin
      pix_wr  = {mid_p, s1_pix_r};
      blur_wr = {mid_b, blur_val};
    end
  end

  // line store read on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_rd_r  <= pix_mem[pos.col];
      blur_rd_r <= blur_mem[pos.col];
    end
  end

  // line store write as the item leaves stage one
  always_ff @(posedge clk) begin
    if (adv1) begin
      pix_mem[s1_pos_r.col]  <= pix_wr;
      blur_mem[s1_pos_r.col] <= blur_wr;
    end
  end

  // stage one item register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos_r <= pos;
      s1_pix_r <= pixel;
    end
  end

  // control and windows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      win_ctl_r  <= '0;
      pwin_r     <= '0;
      bwin_r     <= '0;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !ready2);
      if (adv1) begin
        pwin_r          <= pwin_nxt;
        bwin_r          <= bwin_nxt;
        win_ctl_r.valid <= s1_pos_r.res_en;
        win_ctl_r.last  <= s1_pos_r.last;
      end else if (win_take) begin
        win_ctl_r.valid <= 1'b0;
      end
    end
  end

  assign win_ctl  = win_ctl_r;
  assign blur_win = bwin_r;

endmodule

// File: hdl/gse_grad.sv
// ----------------------------------------------------------------------------
// gse_grad
// sobel gradients, squared magnitude, threshold compare and result register
// ----------------------------------------------------------------------------
module gse_grad import gse_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  win_ctl_t            win_ctl,
  input  blur_win_t           blur_win,
  input  logic [THR_SQ_W-1:0] thr_sq,
  input  logic                out_stall,
  output logic                win_take,
  output logic                out_valid,
  output logic [MAG_W-1:0]    out_magnitude_sq,
  output logic                out_edge_res,
  output logic                out_last_of_frame
);

  logic                      v3_r, v4_r, out_valid_r;
  logic                      last3_r, last4_r;
  logic signed [GRAD_W-1:0]  gx_r, gy_r, gx_nxt, gy_nxt;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  logic signed [2*GRAD_W-1:0] px, py;
  logic [SUM_W-1:0]          mag_sum;
  logic [COLSUM_W-1:0]       left_s, right_s, top_s, bot_s;
  logic [MAG_W-1:0]          mag_r;
  logic                      edge_r, last_r;
  logic                      ready_o, ready4, ready3;

  // weighted 1 2 1 sum of three blurred values
  function automatic logic [COLSUM_W-1:0] sum121(
    input logic [BLUR_W-1:0] a,
    input logic [BLUR_W-1:0] b,
    input logic [BLUR_W-1:0] d
  );
    return COLSUM_W'(a) + (COLSUM_W'(b) << 1) + COLSUM_W'(d);
  endfunction

  // stage readiness
  assign ready_o  = !out_valid_r || !out_stall;
  assign ready4   = !v4_r || ready_o;
  assign ready3   = !v3_r || ready4;
  assign win_take = win_ctl.valid && ready3;

  // gradients
  always_comb begin
    left_s  = sum121(blur_win[0][0], blur_win[1][0], blur_win[2][0]);
    right_s = sum121(blur_win[0][2], blur_win[1][2], blur_win[2][2]);
    top_s   = sum121(blur_win[0][0], blur_win[0][1], blur_win[0][2]);
    bot_s   = sum121(blur_win[2][0], blur_win[2][1], blur_win[2][2]);
    gx_nxt  = $signed({1'b0, right_s}) - $signed({1'b0, left_s});
    gy_nxt  = $signed({1'b0, bot_s}) - $signed({1'b0, top_s});
  end

  // squares and their sum
  assign px      = gx_r * gx_r;
  assign py      = gy_r * gy_r;
  assign mag_sum = SUM_W'(sqx_r) + SUM_W'(sqy_r);

  // datapath registers
  always_ff @(posedge clk) begin
    if (win_take) begin
      gx_r    <= gx_nxt;
      gy_r    <= gy_nxt;
      last3_r <= win_ctl.last;
    end
    if (v3_r && ready4) begin
      sqx_r   <= px[SQ_W-1:0];
      sqy_r   <= py[SQ_W-1:0];
      last4_r <= last3_r;
    end
    if (v4_r && ready_o) begin
      mag_r  <= mag_sum[MAG_W-1:0];
      edge_r <= CMP_W'(mag_sum) >= CMP_W'(thr_sq);
      last_r <= last4_r;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v3_r        <= win_take || (v3_r && !ready4);
      v4_r        <= (v3_r && ready4) || (v4_r && !ready_o);
      out_valid_r <= (v4_r && ready_o) || (out_valid_r && out_stall);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_magnitude_sq  = mag_r;
  assign out_edge_res      = edge_r;
  assign out_last_of_frame = last_r;

endmodule

// File: hdl/gse_checker.sv
// ----------------------------------------------------------------------------
// gse_checker
// port-level checks of the edge detector, bound to the top level
// ----------------------------------------------------------------------------
`include "gaussian_sobel_edge_detect_top_assert.svh"

module gse_checker import gse_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [MAG_W-1:0] out_magnitude_sq,
  input logic             out_edge_res,
  input logic             out_last_of_frame,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // a stalled result item stays put
  `GSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_magnitude_sq) && $stable(out_edge_res) && $stable(out_last_of_frame), "stalled result item changed")

  // input back-pressure only comes from a full, stalled result register
  `GSE_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output back-pressure")

  // config writes are always taken
  `GSE_ASSERT_NOW(a_cfg_taken, cfg_valid, cfg_ready, "config write not taken")

endmodule

bind gaussian_sobel_edge_detect_top gse_checker u_gse_checker (.*);
